@@ rtl/pkt_pkg.sv @@
package pkt_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	// request operations
	localparam logic [1:0] OP_FILL  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// result status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	localparam logic [47:0] QTY_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] QTY_MIN = 48'h8000_0000_0000;

	localparam int MUL_STEPS = 64;
	localparam int DIV_STEPS = 128;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	// datapath commands
	localparam logic [3:0] DOP_NONE     = 4'd0;
	localparam logic [3:0] DOP_LATCH    = 4'd1;
	localparam logic [3:0] DOP_LOAD     = 4'd2;
	localparam logic [3:0] DOP_INIT     = 4'd3;
	localparam logic [3:0] DOP_GAIN_GO  = 4'd4;
	localparam logic [3:0] DOP_GAIN_END = 4'd5;
	localparam logic [3:0] DOP_P1_GO    = 4'd6;
	localparam logic [3:0] DOP_P1_END   = 4'd7;
	localparam logic [3:0] DOP_DIV_GO   = 4'd8;
	localparam logic [3:0] DOP_DIV_END  = 4'd9;
	localparam logic [3:0] DOP_MARK     = 4'd10;
	localparam logic [3:0] DOP_OPEN_END = 4'd11;
	localparam logic [3:0] DOP_EMIT     = 4'd12;
	localparam logic [3:0] DOP_EMIT_ERR = 4'd13;

	typedef struct packed {
		logic [63:0]        strat;
		logic [63:0]        sym_hi;
		logic [55:0]        sym_lo;
		logic signed [47:0] qty;
		logic [47:0]        avg;
		logic [47:0]        mark;
		logic [63:0]        open_pnl;
		logic [63:0]        closed_pnl;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic [3:0]        dop;
		logic [SLOT_W-1:0] addr;
		logic              ram_we;
		logic [5:0]        slot;
		logic              last;
		logic [1:0]        err;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       key_hit;
		logic       sym_hit;
		logic       dq_zero;
		logic       opposite;
		logic       qty_zero;
		logic       arith_done;
		logic       out_free;
	} sts_t;

endpackage

@@ rtl/pkt_ram.sv @@
module pkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic                                         we,
	input  logic [WIDTH-1:0]                             wdata,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/pkt_muldiv.sv @@
module pkt_muldiv import pkt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         mul_go,
	input  logic         div_go,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic         done,
	output logic [127:0] prod,
	output logic [47:0]  quot
);

	logic              busy_q;
	logic              done_q;
	logic              div_q;
	logic [STEP_W-1:0] cnt_q;
	logic [127:0]      acc_q;
	logic [127:0]      mc_q;
	logic [63:0]       mp_q;
	logic [63:0]       rem_q;
	logic [47:0]       q_q;
	logic [64:0]       r2;
	logic              fits;

	// one quotient bit per cycle, restoring
	assign r2   = {rem_q, mc_q[127]};
	assign fits = r2 >= {1'b0, mp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (mul_go) begin
				busy_q <= 1'b1;
				div_q  <= 1'b0;
				cnt_q  <= STEP_W'(MUL_STEPS);
			end else if (div_go) begin
				busy_q <= 1'b1;
				div_q  <= 1'b1;
				cnt_q  <= STEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			acc_q <= '0;
			mc_q  <= {64'd0, a};
			mp_q  <= b;
		end else if (div_go) begin
			mc_q  <= num;
			mp_q  <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			mc_q <= {mc_q[126:0], 1'b0};
			if (div_q) begin
				rem_q <= fits ? 64'(r2 - {1'b0, mp_q}) : r2[63:0];
				q_q   <= {q_q[46:0], fits};
			end else begin
				if (mp_q[0]) begin
					acc_q <= acc_q + mc_q;
				end
				mp_q <= {1'b0, mp_q[63:1]};
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quot = q_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_go || div_go) |-> !busy_q)
		else $error("arith unit started while busy");
	a_go_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_go && div_go))
		else $error("multiply and divide started together");

endmodule

@@ rtl/pkt_dp.sv @@
module pkt_dp import pkt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         operation,
	input  logic [63:0]        strat_key,
	input  logic [63:0]        symbol_high,
	input  logic [55:0]        symbol_low,
	input  logic signed [32:0] qty_delta,
	input  logic [47:0]        price,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic [5:0]         slot,
	output logic signed [47:0] quantity,
	output logic [47:0]        entry_avg,
	output logic [47:0]        mark_px,
	output logic signed [63:0] open_profit,
	output logic signed [63:0] closed_profit,
	output logic               last_result
);

	logic [1:0]   op_q;
	logic [63:0]  strat_q;
	logic [63:0]  symh_q;
	logic [55:0]  syml_q;
	logic [32:0]  dq_q;
	logic [47:0]  price_q;
	rec_t         rec_q;
	logic [127:0] p1_q;
	logic         out_valid_q;

	logic [REC_W-1:0] rd_bits;
	rec_t             rd_rec;
	logic             mul_go, div_go, arith_done;
	logic [63:0]      mul_a, mul_b;
	logic [127:0]     prod;
	logic [47:0]      quot;

	logic [47:0] old_u, aold, adq48, opp_qty, sat_qty;
	logic [32:0] adq, closed_amt;
	logic [48:0] total, neg_total;
	logic [63:0] diff, gain, qty64;
	logic        sym_hit;

	pkt_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.addr  (cmd.addr),
		.we    (cmd.ram_we),
		.wdata (rec_q),
		.rdata (rd_bits)
	);

	assign rd_rec = rec_t'(rd_bits);

	assign old_u      = rec_q.qty;
	assign aold       = old_u[47] ? (~old_u + 48'd1) : old_u;
	assign adq        = dq_q[32] ? (~dq_q + 33'd1) : dq_q;
	assign adq48      = {15'd0, adq};
	assign closed_amt = (adq48 < aold) ? adq : aold[32:0];
	// 64-bit difference is the sign extension of the 49-bit one
	assign diff       = {16'd0, price_q} - {16'd0, rec_q.avg};
	assign total      = {1'b0, aold} + {16'd0, adq};
	assign neg_total  = ~total + 49'd1;
	assign opp_qty    = old_u + {{15{dq_q[32]}}, dq_q};
	assign gain       = old_u[47] ? (64'd0 - prod[63:0]) : prod[63:0];
	assign qty64      = {{16{old_u[47]}}, old_u};

	// saturate the net quantity, the average keeps the full weight
	always_comb begin
		if (!dq_q[32]) begin
			sat_qty = (total > {1'b0, QTY_MAX}) ? QTY_MAX : total[47:0];
		end else begin
			sat_qty = (total > {1'b0, QTY_MIN}) ? QTY_MIN : neg_total[47:0];
		end
	end

	always_comb begin
		mul_go = 1'b0;
		div_go = 1'b0;
		mul_a  = qty64;
		mul_b  = diff;
		unique case (cmd.dop)
			DOP_GAIN_GO: begin
				mul_go = 1'b1;
				mul_a  = {31'd0, closed_amt};
			end
			DOP_P1_GO: begin
				mul_go = 1'b1;
				mul_a  = {16'd0, aold};
				mul_b  = {16'd0, rec_q.avg};
			end
			DOP_P1_END: begin
				mul_go = 1'b1;
				mul_a  = {31'd0, adq};
				mul_b  = {16'd0, price_q};
			end
			DOP_DIV_GO: div_go = 1'b1;
			DOP_MARK:   mul_go = (rec_q.qty != 48'sd0);
			default: ;
		endcase
	end

	pkt_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.mul_go (mul_go),
		.div_go (div_go),
		.a      (mul_a),
		.b      (mul_b),
		.num    (p1_q + prod),
		.den    ({15'd0, total}),
		.done   (arith_done),
		.prod   (prod),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		unique case (cmd.dop)
			DOP_LATCH: begin
				op_q    <= operation;
				strat_q <= strat_key;
				symh_q  <= symbol_high;
				syml_q  <= symbol_low;
				dq_q    <= qty_delta;
				price_q <= price;
			end
			DOP_LOAD: rec_q <= rd_rec;
			DOP_INIT: rec_q <= '{strat: strat_q, sym_hi: symh_q, sym_lo: syml_q, default: '0};
			DOP_GAIN_END: begin
				rec_q.closed_pnl <= rec_q.closed_pnl + gain;
				rec_q.qty        <= opp_qty;
				if (adq48 > aold) begin
					rec_q.avg <= price_q;
				end
			end
			DOP_P1_END: p1_q <= prod;
			DOP_DIV_END: begin
				rec_q.avg <= quot;
				rec_q.qty <= sat_qty;
			end
			DOP_MARK: begin
				rec_q.mark <= price_q;
				if (rec_q.qty == 48'sd0 && op_q == OP_FILL) begin
					rec_q.open_pnl <= '0;
				end
			end
			DOP_OPEN_END: rec_q.open_pnl <= prod[63:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.dop == DOP_EMIT || cmd.dop == DOP_EMIT_ERR) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dop == DOP_EMIT) begin
			status        <= ST_OK;
			slot          <= cmd.slot;
			quantity      <= rec_q.qty;
			entry_avg     <= rec_q.avg;
			mark_px       <= rec_q.mark;
			open_profit   <= rec_q.open_pnl;
			closed_profit <= rec_q.closed_pnl;
			last_result   <= cmd.last;
		end else if (cmd.dop == DOP_EMIT_ERR) begin
			status        <= cmd.err;
			slot          <= '0;
			quantity      <= '0;
			entry_avg     <= '0;
			mark_px       <= '0;
			open_profit   <= '0;
			closed_profit <= '0;
			last_result   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	assign sym_hit = (rd_rec.sym_hi == symh_q) && (rd_rec.sym_lo == syml_q);

	assign sts.op         = op_q;
	assign sts.sym_hit    = sym_hit;
	assign sts.key_hit    = sym_hit && (rd_rec.strat == strat_q);
	assign sts.dq_zero    = (dq_q == 33'd0);
	assign sts.opposite   = (!old_u[47] && old_u != 48'd0 && dq_q[32]) ||
	                        (old_u[47] && !dq_q[32] && dq_q != 33'd0);
	assign sts.qty_zero   = (rec_q.qty == 48'sd0);
	assign sts.arith_done = arith_done;
	assign sts.out_free   = !out_valid_q || out_ready;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dop == DOP_EMIT || cmd.dop == DOP_EMIT_ERR) |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending one");

endmodule

@@ rtl/pkt_ctrl.sv @@
module pkt_ctrl import pkt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RD     = 4'd1;
	localparam logic [3:0] S_CMP    = 4'd2;
	localparam logic [3:0] S_FPREP  = 4'd3;
	localparam logic [3:0] S_GAIN_W = 4'd4;
	localparam logic [3:0] S_P1_W   = 4'd5;
	localparam logic [3:0] S_P2_W   = 4'd6;
	localparam logic [3:0] S_DIV_W  = 4'd7;
	localparam logic [3:0] S_OPEN   = 4'd8;
	localparam logic [3:0] S_OPEN_W = 4'd9;
	localparam logic [3:0] S_WR     = 4'd10;
	localparam logic [3:0] S_EMIT   = 4'd11;
	localparam logic [3:0] S_ERR    = 4'd12;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] used_q, used_d;
	logic [CNT_W-1:0] last_q, last_d;
	logic             found_q, found_d;
	logic             pass2_q, pass2_d;
	logic [1:0]       err_q, err_d;
	logic [CNT_W-1:0] idx_inc;

	assign idx_inc  = idx_q + CNT_W'(1);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		used_d  = used_q;
		last_d  = last_q;
		found_d = found_q;
		pass2_d = pass2_q;
		err_d   = err_q;

		cmd.dop    = DOP_NONE;
		cmd.addr   = idx_q[SLOT_W-1:0];
		cmd.ram_we = 1'b0;
		cmd.slot   = 6'(idx_q);
		cmd.last   = (sts.op != OP_TICK) || (idx_q == last_q);
		cmd.err    = err_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.dop = DOP_LATCH;
					idx_d   = '0;
					found_d = 1'b0;
					pass2_d = 1'b0;
					state_d = S_RD;
				end
			end
			S_RD: begin
				priority if (sts.op != OP_FILL && sts.op != OP_TICK && sts.op != OP_QUERY) begin
					state_d = S_IDLE;
				end else if (idx_q < used_q) begin
					state_d = S_CMP;
				end else if (sts.op == OP_FILL) begin
					if (used_q == CNT_W'(SLOTS)) begin
						err_d   = ST_FULL;
						state_d = S_ERR;
					end else begin
						// new key takes the next free slot, idx equals used here
						cmd.dop = DOP_INIT;
						used_d  = used_q + CNT_W'(1);
						state_d = S_FPREP;
					end
				end else if (sts.op == OP_TICK && found_q) begin
					idx_d   = '0;
					pass2_d = 1'b1;
				end else begin
					err_d   = ST_MISS;
					state_d = S_ERR;
				end
			end
			S_CMP: begin
				unique case (sts.op)
					OP_FILL, OP_QUERY: begin
						if (sts.key_hit) begin
							cmd.dop = DOP_LOAD;
							state_d = (sts.op == OP_FILL) ? S_FPREP : S_EMIT;
						end else begin
							idx_d   = idx_inc;
							state_d = S_RD;
						end
					end
					OP_TICK: begin
						if (!pass2_q) begin
							// first pass only finds the last matching slot
							if (sts.sym_hit) begin
								last_d  = idx_q;
								found_d = 1'b1;
							end
							idx_d   = idx_inc;
							state_d = S_RD;
						end else if (sts.sym_hit) begin
							cmd.dop = DOP_LOAD;
							state_d = S_OPEN;
						end else begin
							idx_d   = idx_inc;
							state_d = S_RD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_FPREP: begin
				priority if (sts.dq_zero) begin
					state_d = S_OPEN;
				end else if (sts.opposite) begin
					cmd.dop = DOP_GAIN_GO;
					state_d = S_GAIN_W;
				end else begin
					cmd.dop = DOP_P1_GO;
					state_d = S_P1_W;
				end
			end
			S_GAIN_W: begin
				if (sts.arith_done) begin
					cmd.dop = DOP_GAIN_END;
					state_d = S_OPEN;
				end
			end
			S_P1_W: begin
				if (sts.arith_done) begin
					cmd.dop = DOP_P1_END;
					state_d = S_P2_W;
				end
			end
			S_P2_W: begin
				if (sts.arith_done) begin
					cmd.dop = DOP_DIV_GO;
					state_d = S_DIV_W;
				end
			end
			S_DIV_W: begin
				if (sts.arith_done) begin
					cmd.dop = DOP_DIV_END;
					state_d = S_OPEN;
				end
			end
			S_OPEN: begin
				cmd.dop = DOP_MARK;
				state_d = sts.qty_zero ? S_WR : S_OPEN_W;
			end
			S_OPEN_W: begin
				if (sts.arith_done) begin
					cmd.dop = DOP_OPEN_END;
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.ram_we = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.dop = DOP_EMIT;
					if (sts.op == OP_TICK && idx_q != last_q) begin
						idx_d   = idx_inc;
						state_d = S_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.dop = DOP_EMIT_ERR;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			used_q  <= '0;
			last_q  <= '0;
			found_q <= 1'b0;
			pass2_q <= 1'b0;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			used_q  <= used_d;
			last_q  <= last_d;
			found_q <= found_d;
			pass2_q <= pass2_d;
			err_q   <= err_d;
		end
	end

	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(SLOTS))
		else $error("slot count beyond table size");
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_RD))
		else $error("compare without a read");
	a_pass2_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD && pass2_q) |-> (idx_q <= last_q && idx_q < used_q))
		else $error("second tick pass ran past last match");

endmodule

@@ rtl/position_keeping_table_top.sv @@
// position keeping table, keyed by strategy id and fifteen-character symbol
// input channel in_valid/in_ready carries one request: fill, price tick or query
// output channel out_valid/out_ready carries result items; last_result marks
// the final one of a request
// a request is taken only while the controller is idle; one result may still
// be waiting in the output register and is held until out_ready
// slot lookup reads the single table memory one slot at a time, passing
// through a read state and then a compare state for each slot
// a fill then runs the shared shift-add multiplier and restoring divider,
// one operation at a time, on the slot it found or took
// a price tick scans the table twice: the first pass over all used slots finds
// the last match, the second runs up to it and updates each matching slot
// a query scans the slots until its key matches; an unused operation ends quietly
// a stalled out_ready holds the controller before it emits the next result
// reset empties the table at once by clearing the slot count; no sweep runs
module position_keeping_table_top import pkt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [63:0]        strat_key,
	input  logic [63:0]        symbol_high,
	input  logic [55:0]        symbol_low,
	input  logic signed [32:0] qty_delta,
	input  logic [47:0]        price,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [5:0]         slot,
	output logic signed [47:0] quantity,
	output logic [47:0]        entry_avg,
	output logic [47:0]        mark_px,
	output logic signed [63:0] open_profit,
	output logic signed [63:0] closed_profit,
	output logic               last_result
);

	cmd_t cmd;
	sts_t sts;

	pkt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pkt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.operation     (operation),
		.strat_key     (strat_key),
		.symbol_high   (symbol_high),
		.symbol_low    (symbol_low),
		.qty_delta     (qty_delta),
		.price         (price),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.slot          (slot),
		.quantity      (quantity),
		.entry_avg     (entry_avg),
		.mark_px       (mark_px),
		.open_profit   (open_profit),
		.closed_profit (closed_profit),
		.last_result   (last_result)
	);

endmodule

@@ verif/tb_position_keeping_table_top.sv @@
module tb_position_keeping_table_top;
	import pkt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [47:0] qty;
		logic [47:0] avg;
		logic [47:0] mark;
		logic [63:0] open_pnl;
		logic [63:0] closed_pnl;
		logic        last;
	} position_rpt_t;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] strat;
		logic [63:0] sym_hi;
		logic [55:0] sym_lo;
		longint      dq;
		logic [47:0] px;
		bit          chk;
		int          n_rpt;
		logic [1:0]  st;
	} directed_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         operation;
	logic [63:0]        strat_key;
	logic [63:0]        symbol_high;
	logic [55:0]        symbol_low;
	logic signed [32:0] qty_delta;
	logic [47:0]        price;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [5:0]         slot;
	logic signed [47:0] quantity;
	logic [47:0]        entry_avg;
	logic [47:0]        mark_px;
	logic signed [63:0] open_profit;
	logic signed [63:0] closed_profit;
	logic               last_result;

	position_keeping_table_top u_dut (.*);

	// position table as the predictor sees it
	bit          pos_used [SLOTS];
	logic [63:0] pos_strat [SLOTS];
	logic [63:0] pos_sym_hi [SLOTS];
	logic [55:0] pos_sym_lo [SLOTS];
	longint      pos_qty [SLOTS];
	logic [47:0] pos_avg [SLOTS];
	logic [47:0] pos_mark [SLOTS];
	logic [63:0] pos_open [SLOTS];
	logic [63:0] pos_closed [SLOTS];
	int          pos_count;

	position_rpt_t pending_rpts [$];
	int errors;
	int tx_idle;
	int rx_idle;
	int rx_hold;
	logic [63:0] sym_hi_pool [4];
	logic [55:0] sym_lo_pool [4];
	logic [63:0] strat_pool [6];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#50ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic logic [63:0] open_value(longint q, logic [47:0] px, logic [47:0] a);
		return 64'(q) * 64'(longint'(px) - longint'(a));
	endfunction

	function automatic position_rpt_t slot_report(int s, bit last);
		position_rpt_t r;
		r.status = ST_OK;
		r.slot = 6'(s);
		r.qty = 48'(pos_qty[s]);
		r.avg = pos_avg[s];
		r.mark = pos_mark[s];
		r.open_pnl = pos_open[s];
		r.closed_pnl = pos_closed[s];
		r.last = last;
		return r;
	endfunction

	function automatic position_rpt_t error_report(logic [1:0] st);
		position_rpt_t r;
		r = '{default: '0};
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic int lookup_key(logic [63:0] strat, logic [63:0] sh, logic [55:0] sl);
		for (int i = 0; i < pos_count; i++)
			if (pos_used[i] && pos_strat[i] == strat && pos_sym_hi[i] == sh && pos_sym_lo[i] == sl)
				return i;
		return -1;
	endfunction

	task automatic apply_fill(int s, longint dq, logic [47:0] px);
		longint      old;
		logic [63:0] a_old;
		logic [63:0] a_dq;
		logic [63:0] closed;
		logic [63:0] gain;
		logic [63:0] total;
		logic [127:0] weight;
		logic [47:0] a;
		bit          opposite;
		old = pos_qty[s];
		a = pos_avg[s];
		a_old = old < 0 ? 64'(-old) : 64'(old);
		a_dq = dq < 0 ? 64'(-dq) : 64'(dq);
		if (dq != 0) begin
			opposite = (old > 0 && dq < 0) || (old < 0 && dq > 0);
			if (opposite) begin
				closed = a_dq < a_old ? a_dq : a_old;
				gain = closed * 64'(longint'(px) - longint'(a));
				if (old < 0)
					gain = -gain;
				pos_closed[s] += gain;
				if (a_dq > a_old)
					a = px;
				pos_qty[s] = old + dq;
			end else begin
				total = a_old + a_dq;
				weight = 128'(a_old) * 128'(a) + 128'(a_dq) * 128'(px);
				a = 48'(weight / 128'(total));
				// net quantity saturates at the 48-bit signed range
				if (dq > 0)
					pos_qty[s] = total > 64'(QTY_MAX) ? 64'(QTY_MAX) : longint'(total);
				else
					pos_qty[s] = total > 64'(QTY_MAX) + 1 ? -(longint'(64'(QTY_MAX)) + 1)
						: -longint'(total);
			end
			pos_avg[s] = a;
		end
		pos_mark[s] = px;
		pos_open[s] = pos_qty[s] != 0 ? open_value(pos_qty[s], px, a) : 64'd0;
	endtask

	// works out the results of one request and queues them; returns count and final status
	task automatic predict_request(logic [1:0] op, logic [63:0] strat, logic [63:0] sh,
			logic [55:0] sl, longint dq, logic [47:0] px, output int n, output logic [1:0] st);
		int s;
		int last_hit;
		n = 0;
		st = ST_OK;
		case (op)
			OP_FILL: begin
				s = lookup_key(strat, sh, sl);
				if (s < 0 && pos_count >= SLOTS) begin
					pending_rpts.push_back(error_report(ST_FULL));
					st = ST_FULL;
				end else begin
					if (s < 0) begin
						s = pos_count++;
						pos_used[s] = 1'b1;
						pos_strat[s] = strat;
						pos_sym_hi[s] = sh;
						pos_sym_lo[s] = sl;
						pos_qty[s] = 0;
						pos_avg[s] = '0;
						pos_mark[s] = '0;
						pos_open[s] = '0;
						pos_closed[s] = '0;
					end
					apply_fill(s, dq, px);
					pending_rpts.push_back(slot_report(s, 1'b1));
				end
				n = 1;
			end
			OP_TICK: begin
				last_hit = -1;
				for (int i = 0; i < pos_count; i++)
					if (pos_used[i] && pos_sym_hi[i] == sh && pos_sym_lo[i] == sl)
						last_hit = i;
				if (last_hit < 0) begin
					pending_rpts.push_back(error_report(ST_MISS));
					st = ST_MISS;
					n = 1;
				end else begin
					for (int i = 0; i <= last_hit; i++) begin
						if (!(pos_used[i] && pos_sym_hi[i] == sh && pos_sym_lo[i] == sl))
							continue;
						pos_mark[i] = px;
						if (pos_qty[i] != 0)
							pos_open[i] = open_value(pos_qty[i], px, pos_avg[i]);
						pending_rpts.push_back(slot_report(i, i == last_hit));
						n++;
					end
				end
			end
			OP_QUERY: begin
				s = lookup_key(strat, sh, sl);
				if (s < 0) begin
					pending_rpts.push_back(error_report(ST_MISS));
					st = ST_MISS;
				end else begin
					pending_rpts.push_back(slot_report(s, 1'b1));
				end
				n = 1;
			end
			default: ;
		endcase
	endtask

	task automatic send_request(logic [1:0] op, logic [63:0] strat, logic [63:0] sh,
			logic [55:0] sl, longint dq, logic [47:0] px, output int n, output logic [1:0] st);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		operation <= op;
		strat_key <= strat;
		symbol_high <= sh;
		symbol_low <= sl;
		qty_delta <= dq[32:0];
		price <= px;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		predict_request(op, strat, sh, sl, dq, px, n, st);
	endtask

	task automatic send_random(bit full_range);
		logic [1:0]  op;
		logic [63:0] strat;
		logic [63:0] sh;
		logic [55:0] sl;
		longint      dq;
		logic [47:0] px;
		int          k;
		int          n;
		logic [1:0]  st;
		k = $urandom_range(0, 99);
		op = k < 55 ? OP_FILL : k < 75 ? OP_TICK : k < 95 ? OP_QUERY : OP_SPARE;
		strat = $urandom_range(0, 9) == 0 ? {$urandom, $urandom} : strat_pool[$urandom_range(0, 5)];
		k = $urandom_range(0, 3);
		sh = sym_hi_pool[k];
		sl = sym_lo_pool[k];
		if ($urandom_range(0, 9) == 0) begin
			sh = {$urandom, $urandom};
			sl = 56'({$urandom, $urandom});
		end
		dq = full_range ? longint'($urandom) : longint'($urandom_range(0, 1000));
		if ($urandom_range(0, 1))
			dq = -dq;
		px = full_range ? 48'({$urandom, $urandom}) : 48'($urandom_range(1, 100000));
		send_request(op, strat, sh, sl, dq, px, n, st);
	endtask

	// receiver side: random back-pressure plus an occasional long hold
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(0, 99) >= rx_idle;
			end
		end
	end

	always @(posedge clk) begin
		position_rpt_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rpts.size() == 0) begin
				report("unexpected result, status", 64'(status), 64'd0);
			end else begin
				w = pending_rpts.pop_front();
				if (status !== w.status) report("status", 64'(status), 64'(w.status));
				if (slot !== w.slot) report("slot", 64'(slot), 64'(w.slot));
				if (quantity !== w.qty) report("quantity", 64'(quantity), 64'(w.qty));
				if (entry_avg !== w.avg)
					report("entry_avg", 64'(entry_avg), 64'(w.avg));
				if (mark_px !== w.mark)
					report("mark_px", 64'(mark_px), 64'(w.mark));
				if (open_profit !== w.open_pnl)
					report("open_profit", open_profit, w.open_pnl);
				if (closed_profit !== w.closed_pnl)
					report("closed_profit", closed_profit, w.closed_pnl);
				if (last_result !== w.last)
					report("last_result", 64'(last_result), 64'(w.last));
			end
		end
	end

	initial begin
		directed_row_t rows [$];
		int n;
		logic [1:0] st;
		logic [63:0] ones64;
		logic [55:0] ones56;
		errors = 0;
		tx_idle = 0;
		rx_idle = 0;
		rx_hold = 0;
		pos_count = 0;
		foreach (pos_used[i])
			pos_used[i] = 1'b0;
		in_valid = 1'b0;
		operation = OP_FILL;
		strat_key = '0;
		symbol_high = '0;
		symbol_low = '0;
		qty_delta = '0;
		price = '0;
		arst_n = 1'b0;
		ones64 = '1;
		ones56 = '1;
		foreach (sym_hi_pool[i]) begin
			sym_hi_pool[i] = {$urandom, $urandom};
			sym_lo_pool[i] = 56'({$urandom, $urandom});
		end
		foreach (strat_pool[i])
			strat_pool[i] = {$urandom, $urandom};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		rows = '{
			'{OP_QUERY, 64'd1, 64'h41, 56'd0, 0, 48'd5, 1, 1, ST_MISS},
			'{OP_TICK, 64'd0, 64'h41, 56'd0, 0, 48'd5, 1, 1, ST_MISS},
			'{OP_SPARE, ones64, ones64, ones56, -1, '1, 1, 0, ST_OK},
			'{OP_FILL, ones64, ones64, ones56, 64'sd4294967295, '1, 0, 1, ST_OK},
			'{OP_FILL, ones64, ones64, ones56, 64'sd4294967295, 48'd1, 0, 1, ST_OK},
			'{OP_FILL, ones64, ones64, ones56, -64'sd4294967295, 48'd7, 0, 1, ST_OK},
			'{OP_FILL, 64'd0, 64'd0, 56'd0, 0, 48'd0, 0, 1, ST_OK},
			'{OP_FILL, 64'd0, 64'd0, 56'd0, -100, 48'd50, 0, 1, ST_OK},
			'{OP_FILL, 64'd0, 64'd0, 56'd0, -50, 48'd80, 0, 1, ST_OK},
			'{OP_FILL, 64'd0, 64'd0, 56'd0, 30, 48'd40, 0, 1, ST_OK},
			'{OP_FILL, 64'd0, 64'd0, 56'd0, 200, 48'd60, 0, 1, ST_OK},
			'{OP_FILL, 64'd0, 64'd0, 56'd0, 0, 48'd65, 0, 1, ST_OK},
			'{OP_FILL, 64'd5, 64'd0, 56'd0, 10, 48'd100, 0, 1, ST_OK},
			'{OP_FILL, 64'd6, 64'd0, 56'd0, 0, 48'd3, 0, 1, ST_OK},
			'{OP_TICK, 64'd9, 64'd0, 56'd0, 0, 48'd120, 0, 3, ST_OK},
			// symbol differing only after the zero character
			'{OP_FILL, 64'd1, 64'h4142_4300_0000_0000, 56'd0, 10, 48'd10, 0, 1, ST_OK},
			'{OP_FILL, 64'd1, 64'h4142_4300_0000_0000, 56'd1, -10, 48'd20, 0, 1, ST_OK},
			'{OP_TICK, 64'd0, 64'h4142_4300_0000_0000, 56'd1, 0, 48'd0, 0, 1, ST_OK},
			'{OP_QUERY, 64'd1, 64'h4142_4300_0000_0000, 56'd0, 0, 48'd0, 0, 1, ST_OK},
			'{OP_QUERY, ones64, ones64, ones56, 0, 48'd0, 0, 1, ST_OK},
			'{OP_TICK, 64'd0, ones64, ones56, 0, '1, 0, 1, ST_OK}
		};
		foreach (rows[i]) begin
			send_request(rows[i].op, rows[i].strat, rows[i].sym_hi, rows[i].sym_lo,
				rows[i].dq, rows[i].px, n, st);
			if (n != rows[i].n_rpt) report("result count of row", 64'(n), 64'(rows[i].n_rpt));
			if (rows[i].chk && st !== rows[i].st)
				report("status of row", 64'(st), 64'(rows[i].st));
		end

		tx_idle = 23;
		rx_idle = 46;
		for (int i = 0; i < 25; i++)
			send_random($urandom_range(0, 3) == 0);

		// long receiver hold while requests keep coming
		rx_hold = 600;
		tx_idle = 0;
		for (int i = 0; i < 10; i++)
			send_random(0);

		// stop offering while the results drain
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_rpts.size() == 0);
		tx_idle = 46;
		rx_idle = 23;
		// fill the table up, then overflow it with new keys
		while (pos_count < SLOTS)
			send_request(OP_FILL, {$urandom, $urandom}, sym_hi_pool[$urandom_range(0, 3)],
				sym_lo_pool[0], longint'($urandom_range(1, 500)), 48'($urandom_range(1, 999)), n, st);
		for (int i = 0; i < 2; i++) begin
			send_request(OP_FILL, {$urandom, $urandom}, sym_hi_pool[1], sym_lo_pool[1],
				5, 48'd9, n, st);
			if (st !== ST_FULL) report("table full status", 64'(st), 64'(ST_FULL));
		end

		for (int i = 0; i < 20; i++)
			send_random($urandom_range(0, 3) == 0);
		tx_idle = 0;
		rx_idle = 0;
		for (int i = 0; i < 20; i++)
			send_random($urandom_range(0, 3) == 0);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_rpts.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ position_keeping_table_top.f @@
rtl/pkt_pkg.sv
rtl/pkt_ram.sv
rtl/pkt_muldiv.sv
rtl/pkt_dp.sv
rtl/pkt_ctrl.sv
rtl/position_keeping_table_top.sv
verif/tb_position_keeping_table_top.sv
